### sv/pvtc_pkg.sv
// Shared types, constants and the hash step for the pending verdict tag checker.
package pvtc_pkg;

	localparam int SLOTS_DEFAULT = 8;

	localparam logic [31:0] FNV_BASIS = 32'h811c9dc5;
	localparam logic [31:0] FNV_PRIME = 32'h01000193;

	localparam int HASH_STEPS = 11;

	localparam logic [1:0] CFG_SESSION_SEED   = 2'd0;
	localparam logic [1:0] CFG_BLOCK_ACTION   = 2'd1;
	localparam logic [1:0] CFG_INVALID_REASON = 2'd2;

	localparam logic [2:0] STATUS_REGISTERED   = 3'd0;
	localparam logic [2:0] STATUS_TABLE_FULL   = 3'd1;
	localparam logic [2:0] STATUS_DUPLICATE    = 3'd2;
	localparam logic [2:0] STATUS_UNKNOWN_ID   = 3'd3;
	localparam logic [2:0] STATUS_TAG_MISMATCH = 3'd4;
	localparam logic [2:0] STATUS_ACCEPTED     = 3'd5;

	localparam logic ACTION_REGISTER = 1'b0;
	localparam logic ACTION_RESPONSE = 1'b1;

	typedef struct packed {
		logic        action;
		logic [15:0] req_id;
		logic [7:0]  verdict_code;
		logic [7:0]  severity;
		logic [7:0]  reason;
		logic        revoke_flag;
		logic [31:0] received_tag;
		logic [63:0] tool_digest;
		logic [31:0] server_time;
		logic [31:0] now_ms;
	} pvtc_in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [2:0]  slot;
		logic        invalidate_first;
		logic [7:0]  audit_action;
		logic [7:0]  audit_reason;
		logic [15:0] audit_target;
		logic        clock_updated;
	} pvtc_out_t;

	typedef struct packed {
		logic [15:0] request;
		logic        done;
		logic [31:0] done_time;
	} pvtc_entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_CHECK,
		ST_FINISH
	} state_t;

	function automatic logic [31:0] fnv_fold(input logic [31:0] h, input logic [7:0] b);
		logic [31:0] x;
		x = h ^ {24'd0, b};
		return 32'(x * FNV_PRIME);
	endfunction

endpackage

### sv/pending_verdict_tag_checker_unit.sv
// Top level of the pending verdict tag checker: slot table walk, tag hash and result register.
//
// Usage: an input transaction on in_data is taken when in_valid is high and in_stall
// is low. A register transaction claims the first free slot of the pending table; a
// response transaction looks up its request id, resolves the slot and checks its
// FNV-1a tag against the received tag. Every input transaction gives exactly one
// result transaction on out_data, held while out_stall is high.
// The slot table lives in a RAM with one read per cycle; each slot visited takes a
// read state and then a compare-and-write-back state. The tag hash folds one byte per
// cycle, eleven bytes, in parallel with the walk. An item is done once both the slot
// walk, which stops at the first hit or after the last slot, and the hash chain have
// finished. The result appears as the unit returns to idle, where the next item can
// be accepted.
// in_stall is high while an item is in work. The next item is accepted while a
// result still waits in the output register; the item after that finishes only
// once the receiver has taken the earlier result.
// Reset clears all slots through per-slot valid bits at once, so no clearing pass
// is needed; configuration takes its reset values. cfg_we writes a register at once.
module pending_verdict_tag_checker_unit #(
	parameter int SLOTS = pvtc_pkg::SLOTS_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  pvtc_pkg::pvtc_in_t in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output pvtc_pkg::pvtc_out_t out_data,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	import pvtc_pkg::*;

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int EW = $bits(pvtc_entry_t);

	state_t state_q, state_d;

	logic [31:0] session_seed_q;
	logic [7:0]  block_action_q;
	logic [7:0]  invalid_reason_q;

	logic [31:0] server_epoch_q;
	logic [31:0] sync_tick_q;
	logic        clock_trusted_q;

	pvtc_in_t    item_q;
	logic [IW-1:0] idx_q;
	logic [SLOTS-1:0] valid_q;
	logic        found_q;
	logic        dup_q;
	logic [IW-1:0] hit_idx_q;

	logic [3:0]  hcnt_q;
	logic [31:0] hash_q;
	logic [7:0]  hash_byte;

	logic        out_valid_q;
	pvtc_out_t   out_q;
	pvtc_out_t   result;

	logic        in_accept;
	logic        out_load;
	logic        idx_step;
	logic        hit_now;
	logic        last_slot;
	logic        hash_done;

	logic        ram_we;
	pvtc_entry_t ram_wdata;
	logic [EW-1:0] ram_rdata;
	pvtc_entry_t entry;

	pvtc_ram #(
		.WIDTH(EW),
		.DEPTH(SLOTS)
	) u_slot_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(idx_q),
		.wdata(ram_wdata),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	assign in_accept = in_valid && !in_stall;
	assign hash_done = (hcnt_q == 4'(HASH_STEPS));
	assign last_slot = (idx_q == IW'(SLOTS - 1));

	always_comb begin
		entry = valid_q[idx_q] ? pvtc_entry_t'(ram_rdata) : '0;
		if (item_q.action == ACTION_REGISTER) begin
			hit_now = !entry.done && (entry.request == 16'd0);
			ram_wdata = '{request: item_q.req_id, done: 1'b0, done_time: 32'd0};
		end else begin
			hit_now = (entry.request == item_q.req_id);
			ram_wdata = '{request: entry.request, done: 1'b1, done_time: item_q.now_ms};
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		ram_we   = 1'b0;
		idx_step = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (hit_now) begin
					ram_we  = !((item_q.action == ACTION_RESPONSE) && entry.done);
					state_d = ST_FINISH;
				end else if (last_slot) begin
					state_d = ST_FINISH;
				end else begin
					idx_step = 1'b1;
					state_d  = ST_READ;
				end
			end
			ST_FINISH: begin
				if (hash_done && (!out_valid_q || !out_stall)) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			session_seed_q   <= FNV_BASIS;
			block_action_q   <= 8'd0;
			invalid_reason_q <= 8'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SESSION_SEED:   session_seed_q   <= cfg_data;
				CFG_BLOCK_ACTION:   block_action_q   <= cfg_data[7:0];
				CFG_INVALID_REASON: invalid_reason_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_q <= in_data;
		end
		if (state_q == ST_CHECK) begin
			found_q   <= hit_now;
			dup_q     <= hit_now && (item_q.action == ACTION_RESPONSE) && entry.done;
			hit_idx_q <= idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= '0;
		end else begin
			if (in_accept) begin
				idx_q <= '0;
			end else if (idx_step) begin
				idx_q <= idx_q + 1'b1;
			end
			if (ram_we) begin
				valid_q[idx_q] <= 1'b1;
			end
		end
	end

	always_comb begin
		case (hcnt_q)
			4'd0:    hash_byte = item_q.req_id[7:0];
			4'd1:    hash_byte = item_q.req_id[15:8];
			4'd2:    hash_byte = item_q.verdict_code;
			4'd3:    hash_byte = item_q.tool_digest[7:0];
			4'd4:    hash_byte = item_q.tool_digest[15:8];
			4'd5:    hash_byte = item_q.tool_digest[23:16];
			4'd6:    hash_byte = item_q.tool_digest[31:24];
			4'd7:    hash_byte = item_q.tool_digest[39:32];
			4'd8:    hash_byte = item_q.tool_digest[47:40];
			4'd9:    hash_byte = item_q.tool_digest[55:48];
			4'd10:   hash_byte = item_q.tool_digest[63:56];
			default: hash_byte = 8'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hcnt_q <= 4'(HASH_STEPS);
		end else if (in_accept) begin
			hcnt_q <= 4'd0;
		end else if (!hash_done) begin
			hcnt_q <= hcnt_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			hash_q <= session_seed_q;
		end else if (!hash_done) begin
			hash_q <= fnv_fold(hash_q, hash_byte);
		end
	end

	always_comb begin
		result = '0;
		if (item_q.action == ACTION_REGISTER) begin
			if (found_q) begin
				result.status = STATUS_REGISTERED;
				result.slot   = 3'(hit_idx_q);
			end else begin
				result.status = STATUS_TABLE_FULL;
			end
		end else if (!found_q) begin
			result.status = STATUS_UNKNOWN_ID;
		end else if (dup_q) begin
			result.status = STATUS_DUPLICATE;
			result.slot   = 3'(hit_idx_q);
		end else begin
			result.slot         = 3'(hit_idx_q);
			result.audit_target = item_q.tool_digest[15:0];
			if (hash_q != item_q.received_tag) begin
				result.status       = STATUS_TAG_MISMATCH;
				result.audit_action = block_action_q;
				result.audit_reason = invalid_reason_q;
			end else begin
				result.status           = STATUS_ACCEPTED;
				result.invalidate_first = item_q.revoke_flag;
				result.audit_action     = item_q.verdict_code;
				result.audit_reason     = item_q.reason;
				result.clock_updated    = (item_q.server_time != 32'd0);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			server_epoch_q  <= 32'd0;
			sync_tick_q     <= 32'd0;
			clock_trusted_q <= 1'b0;
		end else if (out_load && result.clock_updated) begin
			server_epoch_q  <= item_q.server_time;
			sync_tick_q     <= item_q.now_ms;
			clock_trusted_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_accept_starts_walk: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> (state_q == ST_READ) && (idx_q == '0) && (hcnt_q == 4'd0))
		else $error("accepted transaction did not start the slot walk");

	a_write_in_check: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_CHECK) && hit_now)
		else $error("slot table written outside a matching compare");

	a_load_after_hash: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> hash_done && (state_q == ST_FINISH))
		else $error("result loaded before the tag hash finished");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !out_load)
		else $error("waiting result overwritten");

endmodule

### sv/pvtc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module pvtc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### bench/pending_verdict_tag_checker_unit_tb.sv
// Self-checking testbench for the pending verdict tag checker with a built-in slot and tag predictor.
module pending_verdict_tag_checker_unit_tb;
	import pvtc_pkg::*;

	localparam int SLOTS = 8;
	localparam int LONG_HOLD = 300;
	localparam logic [1:0] CFG_SPARE = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	pvtc_in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	pvtc_out_t out_data;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = CFG_SESSION_SEED;
	logic [31:0] cfg_data = '0;

	logic [31:0] seed_reg = FNV_BASIS;
	logic [7:0] block_code = '0;
	logic [7:0] invalid_code = '0;
	logic [15:0] slot_id [SLOTS] = '{default: '0};
	logic slot_done [SLOTS] = '{default: 1'b0};
	logic [31:0] slot_time [SLOTS] = '{default: '0};
	logic [31:0] server_epoch = '0;
	logic [31:0] sync_tick = '0;
	logic clock_trusted = 1'b0;

	pvtc_in_t request_feed [$];
	pvtc_out_t due_outcomes [$];
	logic [15:0] issued_ids [$];
	int mismatches = 0;
	int send_gap = 0;
	int recv_gap = 0;
	int hold_left = 0;
	logic hold_request = 1'b0;
	logic hold_used = 1'b0;
	logic no_gaps = 1'b0;

	pending_verdict_tag_checker_unit #(.SLOTS(SLOTS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	function automatic logic [31:0] verdict_tag(input logic [15:0] id, input logic [7:0] verdict,
			input logic [63:0] hash);
		logic [87:0] stream;
		logic [31:0] h;
		stream = {hash, verdict, id};
		h = seed_reg;
		for (int i = 0; i < 11; i++)
			h = (h ^ {24'd0, stream[8*i +: 8]}) * FNV_PRIME;
		return h;
	endfunction

	function automatic pvtc_out_t predict_outcome(input pvtc_in_t it);
		pvtc_out_t res;
		int hit;
		res = '0;
		res.status = STATUS_TABLE_FULL;
		hit = -1;
		if (it.action == ACTION_REGISTER) begin
			for (int i = 0; i < SLOTS; i++)
				if (hit < 0 && !slot_done[i] && slot_id[i] == 16'd0)
					hit = i;
			if (hit >= 0) begin
				slot_id[hit] = it.req_id;
				slot_done[hit] = 1'b0;
				slot_time[hit] = '0;
				res.status = STATUS_REGISTERED;
				res.slot = 3'(hit);
			end
		end else begin
			for (int i = 0; i < SLOTS; i++)
				if (hit < 0 && slot_id[i] == it.req_id)
					hit = i;
			if (hit < 0) begin
				res.status = STATUS_UNKNOWN_ID;
			end else if (slot_done[hit]) begin
				res.status = STATUS_DUPLICATE;
				res.slot = 3'(hit);
			end else begin
				slot_done[hit] = 1'b1;
				slot_time[hit] = it.now_ms;
				res.slot = 3'(hit);
				res.audit_target = it.tool_digest[15:0];
				if (verdict_tag(it.req_id, it.verdict_code, it.tool_digest) != it.received_tag) begin
					res.status = STATUS_TAG_MISMATCH;
					res.audit_action = block_code;
					res.audit_reason = invalid_code;
				end else begin
					res.status = STATUS_ACCEPTED;
					if (it.server_time != 32'd0) begin
						server_epoch = it.server_time;
						sync_tick = it.now_ms;
						clock_trusted = 1'b1;
						res.clock_updated = 1'b1;
					end
					res.invalidate_first = it.revoke_flag;
					res.audit_action = it.verdict_code;
					res.audit_reason = it.reason;
				end
			end
		end
		return res;
	endfunction

	function automatic pvtc_in_t fresh_item(input logic act, input logic [15:0] id);
		pvtc_in_t it;
		it.action = act;
		it.req_id = id;
		it.verdict_code = 8'($urandom);
		it.severity = 8'($urandom);
		it.reason = 8'($urandom);
		it.revoke_flag = 1'($urandom);
		it.received_tag = $urandom;
		it.tool_digest = {$urandom, $urandom};
		it.server_time = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
		it.now_ms = $urandom;
		return it;
	endfunction

	function automatic pvtc_in_t sealed(input pvtc_in_t it, input bit good);
		logic [31:0] tag;
		tag = verdict_tag(it.req_id, it.verdict_code, it.tool_digest);
		it.received_tag = good ? tag : tag ^ (32'd1 << $urandom_range(0, 31));
		return it;
	endfunction

	function automatic pvtc_in_t random_item();
		pvtc_in_t it;
		logic [15:0] id;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			id = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom);
			if (id != 16'd0)
				issued_ids.push_back(id);
			return fresh_item(ACTION_REGISTER, id);
		end
		if (pick < 75 && issued_ids.size() != 0)
			id = issued_ids[$urandom_range(0, issued_ids.size() - 1)];
		else if (pick < 85)
			id = 16'd0;
		else
			id = 16'($urandom);
		it = fresh_item(ACTION_RESPONSE, id);
		return ($urandom_range(0, 4) == 0) ? it : sealed(it, 1'b1);
	endfunction

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_SESSION_SEED: seed_reg = value;
			CFG_BLOCK_ACTION: block_code = value[7:0];
			CFG_INVALID_REASON: invalid_code = value[7:0];
			default: ;
		endcase
	endtask

	task automatic drain_all();
		do
			@(negedge clk);
		while (request_feed.size() != 0 || in_valid || due_outcomes.size() != 0);
	endtask

	task automatic compare_field(input string field, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%s: expected %0h, actual %0h", field, want, got);
		end
	endtask

	task automatic check_outcome(input pvtc_out_t got);
		pvtc_out_t want;
		if (due_outcomes.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result with nothing pending: %h", got);
			return;
		end
		want = due_outcomes.pop_front();
		compare_field("status", 16'(want.status), 16'(got.status));
		compare_field("slot", 16'(want.slot), 16'(got.slot));
		compare_field("invalidate_first", 16'(want.invalidate_first),
			16'(got.invalidate_first));
		compare_field("audit_action", 16'(want.audit_action), 16'(got.audit_action));
		compare_field("audit_reason", 16'(want.audit_reason), 16'(got.audit_reason));
		compare_field("audit_target", want.audit_target, got.audit_target);
		compare_field("clock_updated", 16'(want.clock_updated), 16'(got.clock_updated));
	endtask

	// Driver: a transaction is held until accepted; gaps start only between transactions.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				due_outcomes.push_back(predict_outcome(in_data));
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (request_feed.size() != 0 && !no_gaps && $urandom_range(0, 5) == 0) begin
					send_gap = $urandom_range(0, 14);
					in_valid <= 1'b0;
				end else if (request_feed.size() != 0) begin
					in_valid <= 1'b1;
					in_data <= request_feed.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (hold_left > 0)
			hold_left <= hold_left - 1;
		else if (hold_request && !hold_used) begin
			hold_left <= LONG_HOLD;
			hold_used <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				check_outcome(out_data);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
			end else if (recv_gap > 0) begin
				recv_gap--;
				out_stall <= 1'b1;
			end else if (!no_gaps && $urandom_range(0, 5) == 0) begin
				recv_gap = $urandom_range(0, 14);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		pvtc_in_t it;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset configuration: nothing registered yet, id zero hits a never-used slot.
		request_feed.push_back(sealed(fresh_item(ACTION_RESPONSE, 16'h1234), 1'b1));
		it = fresh_item(ACTION_RESPONSE, 16'h0000);
		it.verdict_code = '0;
		it.severity = '0;
		it.reason = '0;
		it.revoke_flag = 1'b0;
		it.tool_digest = '0;
		it.server_time = '0;
		it.now_ms = '0;
		request_feed.push_back(sealed(it, 1'b1));
		request_feed.push_back(sealed(fresh_item(ACTION_RESPONSE, 16'h0000), 1'b1));
		request_feed.push_back(fresh_item(ACTION_REGISTER, 16'h0000));
		request_feed.push_back(fresh_item(ACTION_REGISTER, 16'hFFFF));
		request_feed.push_back(fresh_item(ACTION_REGISTER, 16'h0001));
		it = fresh_item(ACTION_RESPONSE, 16'hFFFF);
		it.verdict_code = '1;
		it.severity = '1;
		it.reason = '1;
		it.revoke_flag = 1'b1;
		it.tool_digest = '1;
		it.server_time = '1;
		it.now_ms = '1;
		request_feed.push_back(sealed(it, 1'b1));
		request_feed.push_back(sealed(fresh_item(ACTION_RESPONSE, 16'hFFFF), 1'b1));
		request_feed.push_back(sealed(fresh_item(ACTION_RESPONSE, 16'h0001), 1'b0));
		request_feed.push_back(sealed(fresh_item(ACTION_RESPONSE, 16'h0001), 1'b1));
		request_feed.push_back(sealed(fresh_item(ACTION_RESPONSE, 16'h0002), 1'b1));
		drain_all();

		write_reg(CFG_SESSION_SEED, 32'd0);
		write_reg(CFG_BLOCK_ACTION, 32'hFF);
		write_reg(CFG_INVALID_REASON, 32'hFF);
		write_reg(CFG_SPARE, $urandom);
		@(negedge clk);
		request_feed.push_back(fresh_item(ACTION_REGISTER, 16'h8000));
		request_feed.push_back(fresh_item(ACTION_REGISTER, 16'h00AB));
		it = fresh_item(ACTION_RESPONSE, 16'h8000);
		it.server_time = 32'd1;
		it.revoke_flag = 1'b0;
		request_feed.push_back(sealed(it, 1'b1));
		it = sealed(fresh_item(ACTION_RESPONSE, 16'h00AB), 1'b1);
		it.received_tag = ~it.received_tag;
		request_feed.push_back(it);
		drain_all();

		// The receiver holds off for a long stretch while the sender keeps offering.
		write_reg(CFG_SESSION_SEED, 32'hFFFF_FFFF);
		write_reg(CFG_BLOCK_ACTION, $urandom);
		write_reg(CFG_INVALID_REASON, $urandom);
		@(posedge clk);
		hold_request <= 1'b1;
		@(negedge clk);
		repeat (150) request_feed.push_back(random_item());
		drain_all();

		write_reg(CFG_SESSION_SEED, $urandom);
		write_reg(CFG_BLOCK_ACTION, 32'd0);
		write_reg(CFG_INVALID_REASON, $urandom);
		@(negedge clk);
		repeat (150) request_feed.push_back(random_item());
		drain_all();

		write_reg(CFG_SESSION_SEED, FNV_BASIS);
		write_reg(CFG_BLOCK_ACTION, $urandom);
		write_reg(CFG_INVALID_REASON, 32'd0);
		@(negedge clk);
		no_gaps = 1'b1;
		repeat (150) request_feed.push_back(random_item());
		drain_all();

		repeat (24) @(posedge clk);
		if (mismatches == 0 && due_outcomes.size() == 0)
			$display("pending_verdict_tag_checker_unit test passed");
		else
			$display("pending_verdict_tag_checker_unit test failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("pending_verdict_tag_checker_unit test failed");
		$finish;
	end

endmodule
